// ===== src/voltage_piecewise_linear_limit_unit_assert.svh =====
// Assertion macros used by the checker file of the limit unit
`ifndef VOLTAGE_PIECEWISE_LINEAR_LIMIT_UNIT_ASSERT_SVH
`define VOLTAGE_PIECEWISE_LINEAR_LIMIT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, silent while reset is held
`define VPLU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("limit unit check failed");

// Next-cycle implication, sampled on clk, silent while reset is held
`define VPLU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("limit unit check failed");

`endif

// ===== src/vplu_pkg.sv =====
// Types, codes and constants shared by the voltage limit unit
package vplu_pkg;

	localparam int MAX_SEGMENTS_DEF = 8;
	localparam int SLOT_W           = 3;
	localparam int VOLT_W           = 8;
	localparam int COUNT_CFG_W      = 4;
	localparam int LIMIT_W          = 16;
	localparam int STATUS_W         = 2;
	localparam int DIV_STEPS        = 16;

	localparam logic [15:0] VOLT_CLAMP_LIMIT = 16'h0100;
	localparam logic [7:0]  VOLT_CLAMP_VALUE = 8'd255;

	localparam logic [COUNT_CFG_W-1:0] COUNT_RESET = 4'd1;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_SEGMENT = 2'd2;

	typedef struct packed {
		logic        action;
		logic [2:0]  segment_slot;
		logic [7:0]  seg_threshold;
		logic [7:0]  seg_slope_num;
		logic [7:0]  seg_slope_den;
		logic [15:0] seg_offset;
		logic [15:0] line_voltage;
	} item_t;

	typedef struct packed {
		logic [15:0] limit_value;
		logic [1:0]  status;
		logic [2:0]  segment_used;
	} result_t;

	typedef struct packed {
		logic [7:0]  threshold;
		logic [7:0]  num;
		logic [7:0]  den;
		logic [15:0] offset;
	} seg_t;

endpackage

// ===== src/voltage_piecewise_linear_limit_unit.sv =====
// Voltage piecewise-linear limit unit: sequencer, segment walk and serial divider
//   item / item_valid / item_ready carry one beat per request. A beat with
//   action ACT_WRITE stores one segment slot in the accepting cycle and
//   produces no result. A beat with action ACT_EVAL clamps line_voltage to
//   255, walks the table from slot 0 and returns one result beat on
//   result / result_valid / result_ready.
//   cfg_wr_en / cfg_wr_data set the number of slots searched (reset value 1).
// Sequence: an evaluate visits slots from 0, each with one memory read (FETCH)
//   and one compare (CHECK), then does the 8x8 multiply (MUL), runs the
//   one-bit-a-cycle divider (DIV) and adds the offset as the result beat is
//   registered (DONE). No covering slot or a zero denominator ends it early.
//   The divider and the single table read port set how long it takes.
//   item_ready is high only while the sequencer is idle, so the next beat is
//   taken only after an evaluate has left DONE; writes go back to back.
// Reset idles the sequencer, clears the output valid flag and sets the slot
//   count to 1; the table holds no defined contents until each slot is written.
// Stall: a finished result sits in the output register; the sequencer
//   returns to idle and takes the next beat while that result waits, and
//   holds its next result until the register frees.
module voltage_piecewise_linear_limit_unit #(
	parameter int MAX_SEGMENTS = vplu_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  vplu_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output vplu_pkg::result_t                     result,
	input  logic                                  cfg_wr_en,
	input  logic [vplu_pkg::COUNT_CFG_W-1:0]      cfg_wr_data
);
	import vplu_pkg::*;

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]             state_q;
	logic [COUNT_CFG_W-1:0] seg_count_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_eff;
	logic [IDX_W-1:0]       idx_q;
	logic [VOLT_W-1:0]      volts_q;
	logic [VOLT_W-1:0]      volts_in;
	logic [7:0]             num_q;
	logic [7:0]             den_q;
	logic [15:0]            off_q;
	logic [15:0]            div_q;
	logic [7:0]             rem_q;
	logic [3:0]             step_q;
	logic [STATUS_W-1:0]    st_q;
	logic [2:0]             sel_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic                   item_acc;
	logic                   tbl_wr_en;
	seg_t                   tbl_wr_data;
	seg_t                   tbl_rd_data;
	logic                   last_slot;
	logic [8:0]             trial;
	logic [7:0]             trial_diff;
	logic                   trial_ge;
	logic                   out_free;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign out_free   = !out_valid_q || result_ready;

	// Clamp the slot count to the table depth
	always_comb begin
		if (int'(seg_count_q) > MAX_SEGMENTS) begin
			count_eff = CNT_W'(MAX_SEGMENTS);
		end else begin
			count_eff = CNT_W'(seg_count_q);
		end
	end

	// Clamp the line voltage to eight bits
	assign volts_in = (item.line_voltage >= VOLT_CLAMP_LIMIT) ?
		VOLT_CLAMP_VALUE : item.line_voltage[VOLT_W-1:0];

	// Store a segment on a write beat aimed inside the table
	assign tbl_wr_en = item_acc && (item.action == ACT_WRITE) &&
		(int'(item.segment_slot) < MAX_SEGMENTS);
	assign tbl_wr_data = '{threshold: item.seg_threshold, num: item.seg_slope_num,
		den: item.seg_slope_den, offset: item.seg_offset};

	vplu_seg_table #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.IDX_W        (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (IDX_W'(item.segment_slot)),
		.wr_data (tbl_wr_data),
		.rd_addr (idx_q),
		.rd_data (tbl_rd_data)
	);

	assign last_slot = (int'(idx_q) + 1 >= int'(count_q));

	// Shared subtractor of the restoring divider; the remainder stays below den
	assign trial      = {rem_q, div_q[15]};
	assign trial_diff = trial[7:0] - den_q;
	assign trial_ge   = (trial >= {1'b0, den_q});

	// Hold the slot count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= COUNT_RESET;
		end else if (cfg_wr_en) begin
			seg_count_q <= cfg_wr_data;
		end
	end

	// Sequence the walk, multiply and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.action == ACT_EVAL)) begin
						state_q <= (count_eff == '0) ? ST_DONE : ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (volts_q <= tbl_rd_data.threshold) begin
						state_q <= (tbl_rd_data.den == '0) ? ST_DONE : ST_MUL;
					end else if (last_slot) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == 4'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance the datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				volts_q <= volts_in;
				count_q <= count_eff;
				idx_q   <= '0;
				div_q   <= '0;
				off_q   <= '0;
				sel_q   <= '0;
				st_q    <= STATUS_NO_SEGMENT;
			end
			ST_CHECK: begin
				if (volts_q <= tbl_rd_data.threshold) begin
					num_q <= tbl_rd_data.num;
					den_q <= tbl_rd_data.den;
					sel_q <= 3'(idx_q);
					if (tbl_rd_data.den == '0) begin
						st_q <= STATUS_ZERO_DEN;
					end else begin
						st_q  <= STATUS_OK;
						off_q <= tbl_rd_data.offset;
					end
				end else if (!last_slot) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_MUL: begin
				div_q  <= 16'(volts_q) * 16'(num_q);
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				step_q <= step_q + 4'd1;
				if (trial_ge) begin
					rem_q <= trial_diff;
					div_q <= {div_q[14:0], 1'b1};
				end else begin
					rem_q <= trial[7:0];
					div_q <= {div_q[14:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the result beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= '{limit_value: div_q + off_q, status: st_q, segment_used: sel_q};
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== src/vplu_seg_table.sv =====
// Segment table memory: one write port, one registered read port
module vplu_seg_table #(
	parameter int MAX_SEGMENTS = vplu_pkg::MAX_SEGMENTS_DEF,
	parameter int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  vplu_pkg::seg_t   wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output vplu_pkg::seg_t   rd_data
);
	import vplu_pkg::*;

	seg_t mem [MAX_SEGMENTS];
	seg_t rd_data_q;

	// Store a segment and register the slot under the read pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/vplu_checker.sv =====
// Port-level checks for the voltage limit unit, bound to the top level
`include "voltage_piecewise_linear_limit_unit_assert.svh"

module vplu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input vplu_pkg::item_t                  item,
	input logic                             result_valid,
	input logic                             result_ready,
	input vplu_pkg::result_t                result
);
	import vplu_pkg::*;

	logic eval_acc;

	assign eval_acc = item_valid && item_ready && (item.action == ACT_EVAL);

	// A stalled result beat stays put
	`VPLU_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(result))

	// An evaluate beat blocks the input for at least the following cycle
	`VPLU_ASSERT_NXT(a_eval_busy, eval_acc, !item_ready)

	// No covering segment reports zero value and slot zero
	`VPLU_ASSERT_IMP(a_noseg_zero, result_valid && (result.status == STATUS_NO_SEGMENT),
		(result.limit_value == '0) && (result.segment_used == '0))

	// A zero denominator reports a zero value
	`VPLU_ASSERT_IMP(a_zden_zero, result_valid && (result.status == STATUS_ZERO_DEN),
		result.limit_value == '0)

endmodule

bind voltage_piecewise_linear_limit_unit vplu_checker u_vplu_checker (.*);

// ===== tb/voltage_piecewise_linear_limit_unit_tb.sv =====
// Self-checking testbench for the voltage piecewise-linear limit unit
module voltage_piecewise_linear_limit_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vplu_pkg::*;

	localparam int DRAIN_CYCLES = 2 * MAX_SEGMENTS_DEF + DIV_STEPS + 3 + 24;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AFTER   = 40;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item_beat = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result_beat;
	logic    cfg_wr_en = 1'b0;
	logic [COUNT_CFG_W-1:0] cfg_wr_data = '0;

	// Requests still to be offered, and limit results still owed by the block
	item_t   queued_requests[$];
	result_t expected_limits[$];

	// Shadow of the segment table and the searched-slot count
	seg_t                   shadow_table[MAX_SEGMENTS_DEF];
	logic [COUNT_CFG_W-1:0] shadow_count = COUNT_RESET;

	int  fail_count = 0;
	int  results_seen = 0;
	int  idle_pct = 0;
	bit  quiet_tail = 1'b0;
	logic in_beat_done = 1'b0;
	int  src_idle = 0;
	int  sink_idle = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	voltage_piecewise_linear_limit_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_beat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		fail_count++;
	endtask

	// Store a segment, or work out the limit result an evaluate beat must give
	task automatic predict_limit(item_t req);
		logic [7:0]  volts;
		int unsigned span;
		int unsigned prod;
		int unsigned quot;
		int          sel;
		bit          hit;
		result_t     res;
		if (req.action == ACT_WRITE) begin
			shadow_table[req.segment_slot] = {req.seg_threshold, req.seg_slope_num,
				req.seg_slope_den, req.seg_offset};
		end else begin
			volts = (req.line_voltage >= VOLT_CLAMP_LIMIT) ? VOLT_CLAMP_VALUE
				: req.line_voltage[7:0];
			span = (shadow_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : shadow_count;
			hit = 1'b0;
			sel = 0;
			for (int i = 0; i < span; i++) begin
				if (!hit && volts <= shadow_table[i].threshold) begin
					hit = 1'b1;
					sel = i;
				end
			end
			res = '0;
			if (!hit) begin
				res.status = STATUS_NO_SEGMENT;
			end else if (shadow_table[sel].den == 8'd0) begin
				res.status = STATUS_ZERO_DEN;
				res.segment_used = sel[2:0];
			end else begin
				prod = volts;
				prod = prod * shadow_table[sel].num;
				quot = prod / shadow_table[sel].den;
				quot = quot + shadow_table[sel].offset;
				res.limit_value = quot[15:0];
				res.status = STATUS_OK;
				res.segment_used = sel[2:0];
			end
			expected_limits.push_back(res);
		end
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (expected_limits.size() == 0) begin
			report_mismatch("unrequested result", 0, got);
		end else begin
			want = expected_limits.pop_front();
			if (got.limit_value !== want.limit_value)
				report_mismatch("limit_value", want.limit_value, got.limit_value);
			if (got.status !== want.status)
				report_mismatch("status", want.status, got.status);
			if (got.segment_used !== want.segment_used)
				report_mismatch("segment_used", want.segment_used, got.segment_used);
		end
	endtask

	// Sample both handshakes on the rising edge
	always @(posedge clk) begin
		in_beat_done <= arst_n && item_valid && item_ready;
		if (arst_n && item_valid && item_ready)
			predict_limit(item_beat);
		if (arst_n && result_valid && result_ready) begin
			results_seen <= results_seen + 1;
			check_result(result_beat);
		end
	end

	// Request driver: advance on an accepted beat, otherwise hold
	always @(negedge clk) begin
		if (arst_n && (!item_valid || in_beat_done)) begin
			if (src_idle > 0) begin
				item_valid <= 1'b0;
				src_idle <= src_idle - 1;
			end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
				item_valid <= 1'b0;
				src_idle <= $urandom_range(0, 3);
			end else if (queued_requests.size() != 0) begin
				item_beat <= queued_requests.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			result_ready <= 1'b0;
			hold_left <= LONG_HOLD - 1;
			hold_done <= 1'b1;
		end else if (sink_idle > 0) begin
			result_ready <= 1'b0;
			sink_idle <= sink_idle - 1;
		end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
			result_ready <= 1'b0;
			sink_idle <= $urandom_range(0, 3);
		end else begin
			result_ready <= arst_n;
		end
	end

	function automatic item_t seg_write(logic [2:0] slot, logic [7:0] thr, logic [7:0] num,
		logic [7:0] den, logic [15:0] off);
		item_t req;
		req = '0;
		req.action = ACT_WRITE;
		req.segment_slot = slot;
		req.seg_threshold = thr;
		req.seg_slope_num = num;
		req.seg_slope_den = den;
		req.seg_offset = off;
		return req;
	endfunction

	function automatic item_t volt_eval(logic [15:0] volts);
		item_t req;
		req = '0;
		req.action = ACT_EVAL;
		req.line_voltage = volts;
		return req;
	endfunction

	// Random beat: mostly evaluates, voltages weighted towards the table range
	function automatic item_t make_request();
		item_t req;
		req.action = ($urandom_range(0, 3) == 0) ? ACT_WRITE : ACT_EVAL;
		req.segment_slot = 3'($urandom_range(0, 7));
		req.seg_threshold = 8'($urandom_range(0, 255));
		req.seg_slope_num = 8'($urandom_range(0, 255));
		req.seg_slope_den = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
		req.seg_offset = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: req.line_voltage = 16'($urandom_range(0, 65535));
			3: req.line_voltage = 16'($urandom_range(250, 260));
			default: req.line_voltage = 16'($urandom_range(0, 255));
		endcase
		return req;
	endfunction

	// Wait until every beat is taken and every result is back, then let the block settle
	task automatic wait_drained();
		while (queued_requests.size() != 0 || item_valid || expected_limits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [COUNT_CFG_W-1:0] count);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		shadow_count = count;
	endtask

	initial begin
		int phase_count[8] = '{8, 3, 15, 1, 0, 9, 5, 8};
		int phase_items[8] = '{100, 90, 80, 80, 40, 80, 90, 90};
		int phase_idle[8]  = '{20, 35, 0, 20, 25, 15, 30, 0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every slot first: zero denominator, wrapping offsets, full slopes
		queued_requests.push_back(seg_write(3'd0, 8'd0,   8'd255, 8'd1,   16'h0000));
		queued_requests.push_back(seg_write(3'd1, 8'd10,  8'd3,   8'd0,   16'h1111));
		queued_requests.push_back(seg_write(3'd2, 8'd50,  8'd255, 8'd255, 16'hFFFF));
		queued_requests.push_back(seg_write(3'd3, 8'd100, 8'd200, 8'd7,   16'hFFFF));
		queued_requests.push_back(seg_write(3'd4, 8'd150, 8'd0,   8'd255, 16'd1234));
		queued_requests.push_back(seg_write(3'd5, 8'd200, 8'd255, 8'd1,   16'hFF00));
		queued_requests.push_back(seg_write(3'd6, 8'd254, 8'd17,  8'd3,   16'h8000));
		queued_requests.push_back(seg_write(3'd7, 8'd255, 8'd255, 8'd1,   16'hFFFF));
		// Reset count searches slot 0 only
		queued_requests.push_back(volt_eval(16'd0));
		queued_requests.push_back(volt_eval(16'd1));
		wait_drained();

		// Whole table: clamp edges, zero denominator, segment boundaries
		write_count(4'd8);
		queued_requests.push_back(volt_eval(16'hFFFF));
		queued_requests.push_back(volt_eval(16'h0100));
		queued_requests.push_back(volt_eval(16'h00FF));
		queued_requests.push_back(volt_eval(16'd5));
		queued_requests.push_back(volt_eval(16'd30));
		queued_requests.push_back(volt_eval(16'd100));
		queued_requests.push_back(volt_eval(16'd101));
		queued_requests.push_back(volt_eval(16'd180));
		queued_requests.push_back(volt_eval(16'd250));
		queued_requests.push_back(volt_eval(16'h8000));
		wait_drained();

		// No slot searched at all
		write_count(4'd0);
		queued_requests.push_back(volt_eval(16'd0));
		wait_drained();

		// Count above the table size
		write_count(4'd15);
		queued_requests.push_back(volt_eval(16'd255));
		queued_requests.push_back(volt_eval(16'h1234));
		wait_drained();

		// Random phases over a spread of counts; the last runs without gaps
		for (int p = 0; p < 8; p++) begin
			write_count(COUNT_CFG_W'(phase_count[p]));
			idle_pct = phase_idle[p];
			quiet_tail = (p == 7);
			for (int n = 0; n < phase_items[p]; n++)
				queued_requests.push_back(make_request());
			wait_drained();
		end

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
